/* rtl/fpfa_pkg.sv */
// Shared types and constants for the fixed partition fit allocator.
// Item kinds, placement policy codes, config indexes, controller state and command/status bundles.
// No dependencies.
package fpfa_pkg;

    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int NUMBER_W = 5;
    localparam int COUNT_W  = 16;
    localparam int FREE_W   = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int POLICY_W   = 2;
    localparam int IN_USE_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FREE_W-1:0]  FREE_MAX  = '1;
    localparam logic [IN_USE_W-1:0] IN_USE_RESET = 5'd16;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLACE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

/* rtl/fpfa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fpfa_ctrl.sv */
// Controller for the fit allocator: accept, apply, scan and finish sequencing.
// Depends on fpfa_pkg.
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_FINISH: begin
                cmd.finish = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/fpfa_dp.sv */
// Datapath for the fit allocator: partition table, config registers, counters,
// scan accumulators and result register. Depends on fpfa_pkg and fpfa_ram.
module fpfa_dp
    import fpfa_pkg::*;
#(
    parameter int MAX_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [SLOT_W-1:0]     s_slot,
    input  logic [AMOUNT_W-1:0]   s_amount,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_granted,
    output logic [NUMBER_W-1:0]   m_partition_number,
    output logic [COUNT_W-1:0]    m_request_number,
    output logic [COUNT_W-1:0]    m_unplaced_count,
    output logic [FREE_W-1:0]     m_free_total
);

    localparam int IDX_W  = $clog2(MAX_PARTITIONS);
    localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int ACC_W  = SIZE_BITS + IDX_W + 1;
    localparam int SUM_W  = (ACC_W > FREE_W + 1) ? ACC_W : FREE_W + 1;

    // captured item
    logic [KIND_W-1:0]    kind_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SIZE_BITS-1:0] need_reg;
    logic [47:0]          amount_ext;

    // configuration
    logic [POLICY_W-1:0] policy_reg, policy_next;
    logic [IN_USE_W-1:0] in_use_reg, in_use_next;
    logic [CNT_W-1:0]    active_cnt;

    // table state
    logic [MAX_PARTITIONS-1:0] vld_reg, vld_next;
    logic [MAX_PARTITIONS-1:0] taken_reg, taken_next;
    logic [COUNT_W-1:0]        req_cnt_reg, req_cnt_next;
    logic [COUNT_W-1:0]        unpl_cnt_reg, unpl_cnt_next;

    // scan
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] pick_size_reg, pick_size_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SIZE_BITS-1:0] ram_q;
    logic [SIZE_BITS-1:0] elem_size;
    logic                 elem_taken;
    logic                 issue_en;

    // load
    logic [31:0]      slot_ext;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_ok;
    logic             load_we;

    // result
    logic                is_place;
    logic                grant;
    logic [31:0]         pick_ext;
    logic [SUM_W-1:0]    free_after;
    logic [FREE_W-1:0]   free_sat;
    logic                m_valid_reg, m_valid_next;
    logic                granted_reg;
    logic [NUMBER_W-1:0] number_reg;
    logic [COUNT_W-1:0]  reqn_reg;
    logic [COUNT_W-1:0]  unpl_reg;
    logic [FREE_W-1:0]   free_reg;

    assign amount_ext = {32'd0, s_amount};
    assign slot_ext   = 32'(slot_reg);
    assign slot_idx   = slot_ext[IDX_W-1:0];
    assign slot_ok    = slot_ext < 32'(MAX_PARTITIONS);
    assign load_we    = cmd.apply && (kind_reg == KIND_LOAD) && slot_ok;
    assign is_place   = kind_reg == KIND_PLACE;

    assign active_cnt = (32'(in_use_reg) > 32'(MAX_PARTITIONS)) ?
                        CNT_W'(MAX_PARTITIONS) : CNT_W'(in_use_reg);

    assign issue_en = cmd.scan && (issue_cnt_reg < active_cnt);

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (slot_idx),
        .wdata (need_reg),
        .raddr (issue_cnt_reg[IDX_W-1:0]),
        .rdata (ram_q)
    );

    assign elem_size  = vld_reg[rd_idx_reg] ? ram_q : '0;
    assign elem_taken = taken_reg[rd_idx_reg];

    // configuration writes
    always_comb begin
        policy_next = policy_reg;
        in_use_next = in_use_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_POLICY: policy_next = cfg_data[POLICY_W-1:0];
                CFG_IN_USE: in_use_next = cfg_data[IN_USE_W-1:0];
                default:    policy_next = policy_reg;
            endcase
        end
    end

    // scan of one table entry per cycle, with read data arriving in the cycle after its address
    always_comb begin
        issue_cnt_next = issue_cnt_reg;
        rd_vld_next    = issue_en;
        rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_size_next = pick_size_reg;
        sum_next       = sum_reg;
        if (cmd.apply) begin
            issue_cnt_next = '0;
            found_next     = 1'b0;
            sum_next       = '0;
        end else if (issue_en) begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end
        if (rd_vld_reg && !elem_taken) begin
            sum_next = sum_reg + SUM_W'(elem_size);
            if (elem_size >= need_reg) begin
                if (!found_reg ||
                    (policy_reg == POL_BEST && elem_size < pick_size_reg) ||
                    (policy_reg == POL_WORST && elem_size > pick_size_reg)) begin
                    found_next     = 1'b1;
                    pick_next      = rd_idx_reg;
                    pick_size_next = elem_size;
                end
            end
        end
    end

    assign status.scan_done = issue_cnt_reg == active_cnt;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign grant      = is_place && found_reg;
    assign pick_ext   = 32'(pick_reg) + 32'd1;
    assign free_after = sum_reg - (grant ? SUM_W'(pick_size_reg) : SUM_W'(0));
    assign free_sat   = (free_after > SUM_W'(FREE_MAX)) ? FREE_MAX : free_after[FREE_W-1:0];

    // table and counter updates
    always_comb begin
        vld_next      = vld_reg;
        taken_next    = taken_reg;
        req_cnt_next  = req_cnt_reg;
        unpl_cnt_next = unpl_cnt_reg;
        if (cmd.apply) begin
            case (kind_reg)
                KIND_LOAD: begin
                    if (slot_ok) begin
                        vld_next[slot_idx]   = 1'b1;
                        taken_next[slot_idx] = 1'b0;
                    end
                end
                KIND_PLACE: begin
                    if (req_cnt_reg != COUNT_MAX) begin
                        req_cnt_next = req_cnt_reg + COUNT_W'(1);
                    end
                end
                KIND_CLEAR: begin
                    taken_next    = '0;
                    req_cnt_next  = '0;
                    unpl_cnt_next = '0;
                end
                default: begin
                    vld_next = vld_reg;
                end
            endcase
        end
        if (cmd.finish && is_place) begin
            if (found_reg) begin
                taken_next[pick_reg] = 1'b1;
            end else if (unpl_cnt_reg != COUNT_MAX) begin
                unpl_cnt_next = unpl_cnt_reg + COUNT_W'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg    <= POL_FIRST;
            in_use_reg    <= IN_USE_RESET;
            vld_reg       <= '0;
            taken_reg     <= '0;
            req_cnt_reg   <= '0;
            unpl_cnt_reg  <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            policy_reg    <= policy_next;
            in_use_reg    <= in_use_next;
            vld_reg       <= vld_next;
            taken_reg     <= taken_next;
            req_cnt_reg   <= req_cnt_next;
            unpl_cnt_reg  <= unpl_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            slot_reg <= s_slot;
            need_reg <= amount_ext[SIZE_BITS-1:0];
        end
        rd_idx_reg    <= rd_idx_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        sum_reg       <= sum_next;
        if (cmd.finish) begin
            granted_reg <= grant;
            number_reg  <= grant ? pick_ext[NUMBER_W-1:0] : '0;
            reqn_reg    <= req_cnt_reg;
            unpl_reg    <= unpl_cnt_next;
            free_reg    <= free_sat;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_granted          = granted_reg;
    assign m_partition_number = number_reg;
    assign m_request_number   = reqn_reg;
    assign m_unplaced_count   = unpl_reg;
    assign m_free_total       = free_reg;

endmodule

/* rtl/fixed_partition_fit_allocator_unit.sv */
// Top level of the fixed partition fit allocator (first, best and worst fit).
// Depends on fpfa_pkg, fpfa_ctrl and fpfa_dp (which holds fpfa_ram).
//
// Usage:
//   Input channel s_*: one item per transfer; s_kind selects load partition size,
//   place request or clear all allocations. Result channel m_*: exactly one
//   result transfer per input item, in order.
//   Config port cfg_*: index 0 sets the placement policy, index 1 the number of
//   partitions in use. Write only while no item is in flight.
// Timing:
//   One item at a time. Each item passes through the apply, scan and finish
//   steps before the next input transfer is possible. The cost is the
//   sequential scan of the size RAM over the clamped partitions-in-use count,
//   one entry per cycle, plus the registered RAM read. The result is
//   registered by the finish step that follows the scan.
// Reset:
//   aresetn clears all taken marks, size valid bits and counters and loads
//   the config defaults (first fit, 16 partitions); sizes read as zero until loaded.
// Stalls:
//   A held result sits in the output register while the next item is accepted
//   and scanned; that item then waits to finish until the result is taken.
module fixed_partition_fit_allocator_unit
    import fpfa_pkg::*;
#(
    parameter int MAX_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [SLOT_W-1:0]     s_slot,
    input  logic [AMOUNT_W-1:0]   s_amount,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_granted,
    output logic [NUMBER_W-1:0]   m_partition_number,
    output logic [COUNT_W-1:0]    m_request_number,
    output logic [COUNT_W-1:0]    m_unplaced_count,
    output logic [FREE_W-1:0]     m_free_total
);

    cmd_t    cmd;
    status_t status;

    fpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fpfa_dp #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_kind             (s_kind),
        .s_slot             (s_slot),
        .s_amount           (s_amount),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_granted          (m_granted),
        .m_partition_number (m_partition_number),
        .m_request_number   (m_request_number),
        .m_unplaced_count   (m_unplaced_count),
        .m_free_total       (m_free_total)
    );

    // an accepted item moves straight into the apply step
    a_accept_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> cmd.apply)
        else $error("accepted item did not enter apply step");

    // finishing never overwrites a result that is still stalled
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(m_valid && !m_ready))
        else $error("result register overwritten while stalled");

    // a new result only appears after a finish step
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.finish))
        else $error("result valid without finish");

    // no partition number without a grant
    a_number_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_granted |-> m_partition_number == '0)
        else $error("partition number reported without grant");

endmodule
